FILE: hw/rtl/gb3_pkg.sv
// shared types, constants and coefficient helper for the 3x3 gaussian blur block
package gb3_pkg;

	localparam int unsigned MAX_WIDTH_DEF  = 1024;
	localparam int unsigned MAX_HEIGHT_DEF = 1024;
	localparam int unsigned COEF_FRAC_DEF  = 16;

	localparam int unsigned CFG_WIDTH    = 11;
	localparam int unsigned RESET_WIDTH  = 640;
	localparam int unsigned RESET_HEIGHT = 480;

	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	// weights in parts per million
	localparam longint unsigned PPM_CORNER = 64'd102059;
	localparam longint unsigned PPM_EDGE   = 64'd115349;
	localparam longint unsigned PPM_CENTRE = 64'd130371;

	localparam int unsigned OUT_DEPTH = 8;

	typedef struct packed {
		logic [7:0] blurred_value;
		logic       mask_bit;
		logic       frame_last;
	} result_t;

	typedef struct packed {
		logic top_ok;
		logic bot_ok;
		logic left_ok;
		logic right_ok;
		logic last;
	} win_mask_t;

	function automatic longint unsigned coef_q(input longint unsigned ppm, input int unsigned frac);
		return ((ppm << frac) + 64'd500000) / 64'd1000000;
	endfunction

endpackage

FILE: hw/rtl/gb3_pixel_if.sv
// pixel input channel
interface gb3_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel_value;
	logic       flush;

	modport source (output valid, output pixel_value, output flush, input ready);
	modport sink (input valid, input pixel_value, input flush, output ready);
endinterface

FILE: hw/rtl/gb3_result_if.sv
// result output channel
interface gb3_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] blurred_value;
	logic       mask_bit;
	logic       frame_last;

	modport source (output valid, output blurred_value, output mask_bit, output frame_last,
		input ready);
	modport sink (input valid, input blurred_value, input mask_bit, input frame_last,
		output ready);
endinterface

FILE: hw/rtl/gb3_out_fifo.sv
// result queue in front of the output channel
module gb3_out_fifo import gb3_pkg::*; #(
	parameter int unsigned DEPTH = OUT_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  result_t   push_data,
	gb3_result_if.source result
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	result_t          store_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             pop;
	result_t          head;

	assign pop = result.valid && result.ready;
	assign head = store_q[rd_ptr_q];

	assign result.valid         = (count_q != '0);
	assign result.blurred_value = head.blurred_value;
	assign result.mask_bit      = head.mask_bit;
	assign result.frame_last    = head.frame_last;

	always_ff @(posedge clk) begin
		if (push) store_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				if (wr_ptr_q == AW'(DEPTH - 1)) wr_ptr_q <= '0;
				else wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (pop) begin
				if (rd_ptr_q == AW'(DEPTH - 1)) rd_ptr_q <= '0;
				else rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			if (push && !pop) count_q <= count_q + CNT_W'(1);
			else if (pop && !push) count_q <= count_q - CNT_W'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < CNT_W'(DEPTH)) || pop)
		else $error("result queue overflow");

endmodule

FILE: hw/rtl/gaussian_blur_3x3_threshold.sv
// top level: streaming 3x3 gaussian blur with nonzero mask
// Pixels enter on the pixel channel in raster order, one beat per pixel, and
// results leave on the result channel, one beat per frame position.
// Configuration: cfg_wr_en with cfg_index 0 (frame width) or 1 (frame height)
// writes cfg_data, clamped to [2, MAX_*]; a write restarts the frame.
// A flush beat inside the frame body is dropped; after the last pixel of a
// frame, frame width + 1 beats (flush or not) drain the remaining results.
// Throughput: one beat per cycle while a result slot is free; the line stores sit in one
// dual-row memory, read when a pixel is accepted and written back in the following cycle.
// Result path: the result for a pixel is produced when the pixel one row and one
// column later is accepted, then passes the memory read at the accepting edge, the
// window, the group sums, the weighting and the queue before it is valid on the output.
// Reset: width 640 and height 480 (clamped), position counters and window
// cleared; the line memory holds no reset value and is never read unwritten
// where it matters.
// Stall: results wait in an 8-entry queue; the input is held off once the
// queue plus the items in flight would fill it, so nothing is lost.
module gaussian_blur_3x3_threshold import gb3_pkg::*; #(
	parameter int unsigned MAX_WIDTH          = MAX_WIDTH_DEF,
	parameter int unsigned MAX_HEIGHT         = MAX_HEIGHT_DEF,
	parameter int unsigned COEF_FRACTION_BITS = COEF_FRAC_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	gb3_pixel_if.sink            pixel,
	gb3_result_if.source         result,
	input  logic                 cfg_wr_en,
	input  logic                 cfg_index,
	input  logic [CFG_WIDTH-1:0] cfg_data
);

	localparam int unsigned CW    = $clog2(MAX_WIDTH);
	localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
	localparam int unsigned HW    = $clog2(MAX_HEIGHT + 1);
	localparam int unsigned ORW   = $clog2(MAX_HEIGHT);
	localparam int unsigned F     = COEF_FRACTION_BITS;
	localparam int unsigned SW    = F + 10;
	localparam int unsigned OCC_W = $clog2(OUT_DEPTH + 1);

	localparam logic [F-1:0] W_CORNER = F'(coef_q(PPM_CORNER, F));
	localparam logic [F-1:0] W_EDGE   = F'(coef_q(PPM_EDGE, F));
	localparam logic [F-1:0] W_CENTRE = F'(coef_q(PPM_CENTRE, F));

	localparam int unsigned RST_W = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
	localparam int unsigned RST_H = (RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT;

	function automatic logic [WW-1:0] clamp_w(input logic [CFG_WIDTH-1:0] v);
		if (v < CFG_WIDTH'(2)) return WW'(2);
		if (32'(v) > MAX_WIDTH) return WW'(MAX_WIDTH);
		return WW'(v);
	endfunction

	function automatic logic [HW-1:0] clamp_h(input logic [CFG_WIDTH-1:0] v);
		if (v < CFG_WIDTH'(2)) return HW'(2);
		if (32'(v) > MAX_HEIGHT) return HW'(MAX_HEIGHT);
		return HW'(v);
	endfunction

	// frame geometry and positions
	logic [WW-1:0]  width_q;
	logic [HW-1:0]  height_q;
	logic [CW-1:0]  in_col_q;
	logic [HW-1:0]  in_row_q;
	logic [CW-1:0]  out_col_q;
	logic [ORW-1:0] out_row_q;
	logic [OCC_W-1:0] occ_q;

	logic      take, live, draining, emit, in_col_end, out_col_end, out_row_end;
	logic [7:0] pix_in;
	win_mask_t mask_in;

	// pipeline
	logic           v_s1, emit_s1, fwd_s1;
	logic [7:0]     pix_s1;
	logic [CW-1:0]  col_s1;
	win_mask_t      flags_s1;
	logic [15:0]    rd_q;
	logic [15:0]    fwd_data_s1;
	logic [15:0]    line_rd;

	logic [15:0]    line_mem [MAX_WIDTH];
	logic [7:0]     win_q [9];

	logic           v_s2;
	win_mask_t      flags_s2;
	logic [9:0]     corner_sum, edge_sum;

	logic           v_s3, last_s3;
	logic [9:0]     corner_s3, edge_s3;
	logic [7:0]     centre_s3;

	logic           v_s4, last_s4;
	logic [SW-1:0]  sum_s4;
	logic [SW-1:0]  rnd;
	logic [SW-F-1:0] whole;
	result_t        res;
	logic           pop;

	assign take     = pixel.valid && pixel.ready;
	assign draining = (in_row_q >= height_q);
	assign live     = take && !(pixel.flush && !draining);
	assign pix_in   = draining ? 8'd0 : pixel.pixel_value;
	assign emit     = (in_row_q >= HW'(2)) || ((in_row_q == HW'(1)) && (in_col_q != '0));

	assign in_col_end  = (WW'(in_col_q) == width_q - WW'(1));
	assign out_col_end = (WW'(out_col_q) == width_q - WW'(1));
	assign out_row_end = (HW'(out_row_q) == height_q - HW'(1));

	assign mask_in.top_ok   = (out_row_q != '0);
	assign mask_in.bot_ok   = !out_row_end;
	assign mask_in.left_ok  = (out_col_q != '0);
	assign mask_in.right_ok = !out_col_end;
	assign mask_in.last     = out_col_end && out_row_end;

	assign pop = result.valid && result.ready;
	assign pixel.ready = (occ_q < OCC_W'(OUT_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= WW'(RST_W);
			height_q  <= HW'(RST_H);
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  width_q <= clamp_w(cfg_data);
				REG_FRAME_HEIGHT: height_q <= clamp_h(cfg_data);
				default: ;
			endcase
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (live) begin
			if (emit && mask_in.last) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				if (in_col_end) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + HW'(1);
				end else begin
					in_col_q <= in_col_q + CW'(1);
				end
				if (emit) begin
					if (out_col_end) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + ORW'(1);
					end else begin
						out_col_q <= out_col_q + CW'(1);
					end
				end
			end
		end
	end

	// result slots reserved from accept until the output beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			if ((live && emit) && !pop) occ_q <= occ_q + OCC_W'(1);
			else if (pop && !(live && emit)) occ_q <= occ_q - OCC_W'(1);
		end
	end

	// line memory: upper row in the high byte, middle row in the low byte
	assign line_rd = fwd_s1 ? fwd_data_s1 : rd_q;

	always_ff @(posedge clk) begin
		if (v_s1) line_mem[col_s1] <= {line_rd[7:0], pix_s1};
		if (live) rd_q <= line_mem[in_col_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			fwd_s1 <= 1'b0;
		end else begin
			v_s1   <= live;
			fwd_s1 <= live && v_s1 && (col_s1 == in_col_q);
		end
	end

	always_ff @(posedge clk) begin
		if (live) begin
			pix_s1      <= pix_in;
			col_s1      <= in_col_q;
			emit_s1     <= emit;
			flags_s1    <= mask_in;
			fwd_data_s1 <= {line_rd[7:0], pix_s1};
		end
	end

	// 3x3 window, rightmost column takes the new column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) win_q[i] <= '0;
		end else if (cfg_wr_en) begin
			for (int i = 0; i < 9; i++) win_q[i] <= '0;
		end else if (v_s1) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r*3]     <= win_q[r*3 + 1];
				win_q[r*3 + 1] <= win_q[r*3 + 2];
			end
			win_q[2] <= line_rd[15:8];
			win_q[5] <= line_rd[7:0];
			win_q[8] <= pix_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s2 <= v_s1 && emit_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) flags_s2 <= flags_s1;
	end

	// masked group sums, one weight per group
	always_comb begin
		corner_sum = '0;
		edge_sum   = '0;
		if (flags_s2.top_ok && flags_s2.left_ok) corner_sum = corner_sum + 10'(win_q[0]);
		if (flags_s2.top_ok && flags_s2.right_ok) corner_sum = corner_sum + 10'(win_q[2]);
		if (flags_s2.bot_ok && flags_s2.left_ok) corner_sum = corner_sum + 10'(win_q[6]);
		if (flags_s2.bot_ok && flags_s2.right_ok) corner_sum = corner_sum + 10'(win_q[8]);
		if (flags_s2.top_ok) edge_sum = edge_sum + 10'(win_q[1]);
		if (flags_s2.left_ok) edge_sum = edge_sum + 10'(win_q[3]);
		if (flags_s2.right_ok) edge_sum = edge_sum + 10'(win_q[5]);
		if (flags_s2.bot_ok) edge_sum = edge_sum + 10'(win_q[7]);
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			corner_s3 <= corner_sum;
			edge_s3   <= edge_sum;
			centre_s3 <= win_q[4];
			last_s3   <= flags_s2.last;
		end
		if (v_s3) begin
			sum_s4  <= SW'(corner_s3) * SW'(W_CORNER) + SW'(edge_s3) * SW'(W_EDGE)
				+ SW'(centre_s3) * SW'(W_CENTRE);
			last_s4 <= last_s3;
		end
	end

	assign rnd   = sum_s4 + (SW'(1) << (F - 1));
	assign whole = rnd[SW-1:F];

	assign res.blurred_value = (whole > (SW-F)'(255)) ? 8'd255 : whole[7:0];
	assign res.mask_bit      = (sum_s4 != '0);
	assign res.frame_last    = last_s4;

	gb3_out_fifo #(
		.DEPTH(OUT_DEPTH)
	) u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s4),
		.push_data (res),
		.result    (result)
	);

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(OUT_DEPTH))
		else $error("result slot count beyond queue depth");

	a_inflight_reserved: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({v_s1 && emit_s1, v_s2, v_s3, v_s4}) <= int'(occ_q))
		else $error("result in flight without a reserved slot");

	a_last_restart: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && emit_s1 && flags_s1.last
		|-> (in_col_q == '0) && (in_row_q == '0) && (out_col_q == '0) && (out_row_q == '0))
		else $error("frame end did not restart positions");

endmodule

FILE: dv/testbench.sv
// self-checking testbench for the streaming 3x3 gaussian blur with nonzero mask
module testbench import gb3_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum int {PAT_RANDOM, PAT_ZERO, PAT_FULL, PAT_SPARSE, PAT_EXTREME} pixel_pattern_t;

	localparam longint unsigned W_CORNER = ((64'd102059 << COEF_FRAC_DEF) + 64'd500000) / 64'd1000000;
	localparam longint unsigned W_EDGE   = ((64'd115349 << COEF_FRAC_DEF) + 64'd500000) / 64'd1000000;
	localparam longint unsigned W_CENTRE = ((64'd130371 << COEF_FRAC_DEF) + 64'd500000) / 64'd1000000;

	localparam int LONG_HOLD      = 400;
	localparam int SETTLE_CYCLES  = 16;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int RANDOM_BEATS   = 650;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic                 cfg_index;
	logic [CFG_WIDTH-1:0] cfg_data;

	gb3_pixel_if  pixel();
	gb3_result_if result();

	gaussian_blur_3x3_threshold i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixel     (pixel),
		.result    (result),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// blur predictor state
	logic [7:0]  row_above  [MAX_WIDTH_DEF];
	logic [7:0]  row_middle [MAX_WIDTH_DEF];
	logic [7:0]  win_px     [9];
	int unsigned geom_width;
	int unsigned geom_height;
	int unsigned in_col;
	int unsigned in_row;
	int unsigned out_col;
	int unsigned out_row;

	result_t expected_results[$];

	int mismatch_count = 0;
	int quiet_cycles   = 0;
	int stream_beats   = 0;
	int gap_pct        = 20;
	int stall_pct      = 20;
	bit hold_request   = 1'b0;

	task automatic restart_frame();
		for (int i = 0; i < 9; i++) begin
			win_px[i] = 8'd0;
		end
		in_col  = 0;
		in_row  = 0;
		out_col = 0;
		out_row = 0;
	endtask

	function automatic int unsigned clamp_geometry(input logic [CFG_WIDTH-1:0] value,
		input int unsigned hi);
		if (value < 2) begin
			return 2;
		end
		if (value > hi) begin
			return hi;
		end
		return value;
	endfunction

	task automatic predict_blur(input logic [7:0] pv, input logic fl);
		bit              draining;
		bit              emit;
		bit              frame_end;
		logic [7:0]      px;
		logic [7:0]      top;
		logic [7:0]      mid;
		longint unsigned sum;
		longint unsigned wt;
		longint unsigned rounded;
		result_t         res;
		int              r;
		int              c;
		draining = in_row >= geom_height;
		if (fl && !draining) begin
			return;
		end
		px  = draining ? 8'd0 : pv;
		top = row_above[in_col];
		mid = row_middle[in_col];
		row_above[in_col]  = mid;
		row_middle[in_col] = px;
		for (r = 0; r < 3; r++) begin
			win_px[r*3]   = win_px[r*3+1];
			win_px[r*3+1] = win_px[r*3+2];
		end
		win_px[2] = top;
		win_px[5] = mid;
		win_px[8] = px;
		emit = in_row >= 2 || (in_row == 1 && in_col >= 1);
		if (in_col + 1 >= geom_width) begin
			in_col = 0;
			in_row++;
		end else begin
			in_col++;
		end
		if (!emit) begin
			return;
		end
		sum = 0;
		for (r = 0; r < 3; r++) begin
			for (c = 0; c < 3; c++) begin
				if (!((r == 0 && out_row == 0) || (r == 2 && out_row + 1 >= geom_height) ||
					(c == 0 && out_col == 0) || (c == 2 && out_col + 1 >= geom_width))) begin
					wt = (r == 1 && c == 1) ? W_CENTRE : ((r == 1 || c == 1) ? W_EDGE : W_CORNER);
					sum += longint'(win_px[r*3+c]) * wt;
				end
			end
		end
		rounded = (sum + (64'd1 << (COEF_FRAC_DEF - 1))) >> COEF_FRAC_DEF;
		if (rounded > 255) begin
			rounded = 255;
		end
		frame_end = out_col + 1 >= geom_width && out_row + 1 >= geom_height;
		res.blurred_value = rounded[7:0];
		res.mask_bit      = sum != 0;
		res.frame_last    = frame_end;
		expected_results.push_back(res);
		if (frame_end) begin
			in_col  = 0;
			in_row  = 0;
			out_col = 0;
			out_row = 0;
		end else if (out_col + 1 >= geom_width) begin
			out_col = 0;
			out_row++;
		end else begin
			out_col++;
		end
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] next_pixel(input pixel_pattern_t pattern);
		case (pattern)
			PAT_ZERO: begin
				return 8'd0;
			end
			PAT_FULL: begin
				return 8'd255;
			end
			PAT_SPARSE: begin
				return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
			end
			PAT_EXTREME: begin
				case ($urandom_range(0, 5))
					0: return 8'd0;
					1: return 8'd1;
					2: return 8'd127;
					3: return 8'd128;
					4: return 8'd254;
					default: return 8'd255;
				endcase
			end
			default: begin
				return 8'($urandom_range(0, 255));
			end
		endcase
	endfunction

	// pixel beat monitor, prediction and result check
	always @(posedge clk) begin
		result_t exp_res;
		if ((pixel.valid && pixel.ready) || (result.valid && result.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
		if (result.valid && result.ready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result beat: blurred_value %0d, mask_bit %0d, frame_last %0d",
					result.blurred_value, result.mask_bit, result.frame_last);
				mismatch_count++;
			end else begin
				exp_res = expected_results.pop_front();
				if (result.blurred_value !== exp_res.blurred_value) begin
					$error("blurred_value: expected %0d, actual %0d",
						exp_res.blurred_value, result.blurred_value);
					mismatch_count++;
				end
				if (result.mask_bit !== exp_res.mask_bit) begin
					$error("mask_bit: expected %0d, actual %0d", exp_res.mask_bit, result.mask_bit);
					mismatch_count++;
				end
				if (result.frame_last !== exp_res.frame_last) begin
					$error("frame_last: expected %0d, actual %0d",
						exp_res.frame_last, result.frame_last);
					mismatch_count++;
				end
			end
		end
		if (pixel.valid && pixel.ready) begin
			predict_blur(pixel.pixel_value, pixel.flush);
		end
	end

	// result side back-pressure
	initial begin
		int stall_left;
		stall_left = 0;
		result.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				stall_left = LONG_HOLD;
			end else if (stall_left == 0 && $urandom_range(0, 99) < stall_pct) begin
				stall_left = pick_gap();
			end
			if (stall_left > 0) begin
				result.ready <= 1'b0;
				stall_left--;
			end else begin
				result.ready <= 1'b1;
			end
		end
	end

	task automatic send_beat(input logic [7:0] pv, input logic fl);
		int gap;
		gap = 0;
		if ($urandom_range(0, 99) < gap_pct) begin
			gap = pick_gap();
		end
		if (gap > 0) begin
			pixel.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixel.valid       <= 1'b1;
		pixel.pixel_value <= pv;
		pixel.flush       <= fl;
		@(posedge clk);
		while (!pixel.ready) begin
			@(posedge clk);
		end
	endtask

	task automatic wait_drained();
		while (expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_geometry(input logic idx, input logic [CFG_WIDTH-1:0] value);
		pixel.valid <= 1'b0;
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		if (idx == REG_FRAME_WIDTH) begin
			geom_width = clamp_geometry(value, MAX_WIDTH_DEF);
		end else begin
			geom_height = clamp_geometry(value, MAX_HEIGHT_DEF);
		end
		restart_frame();
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// one frame in raster order, stray flushes in the body, then the drain beats
	task automatic send_frame(input pixel_pattern_t pattern, input int stray_pct,
		input int drain_beats);
		int n;
		n = geom_width * geom_height;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < stray_pct) begin
				send_beat(8'($urandom_range(0, 255)), 1'b1);
			end
			send_beat(next_pixel(pattern), 1'b0);
			stream_beats++;
		end
		for (int i = 0; i < drain_beats; i++) begin
			send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			stream_beats++;
		end
	endtask

	task automatic test_reset_geometry();
		for (int i = 0; i < RESET_WIDTH + 5; i++) begin
			send_beat(next_pixel(PAT_RANDOM), 1'b0);
		end
	endtask

	task automatic test_saturation();
		write_geometry(REG_FRAME_WIDTH, 11'd3);
		write_geometry(REG_FRAME_HEIGHT, 11'd3);
		send_frame(PAT_FULL, 0, geom_width + 1);
	endtask

	// a single faint pixel sets the mask while the blur rounds to zero
	task automatic test_faint_pixel();
		write_geometry(REG_FRAME_WIDTH, 11'd2);
		write_geometry(REG_FRAME_HEIGHT, 11'd2);
		send_beat(8'd1, 1'b0);
		send_beat(8'd255, 1'b1);
		send_beat(8'd0, 1'b0);
		send_beat(8'd0, 1'b0);
		send_beat(8'd0, 1'b0);
		send_beat(8'd255, 1'b0);
		send_beat(8'd170, 1'b0);
		send_beat(8'd85, 1'b1);
	endtask

	task automatic test_geometry_extremes();
		write_geometry(REG_FRAME_WIDTH, 11'd0);
		write_geometry(REG_FRAME_HEIGHT, 11'd1);
		send_frame(PAT_RANDOM, 0, geom_width + 1);
		write_geometry(REG_FRAME_WIDTH, 11'd1);
		write_geometry(REG_FRAME_HEIGHT, 11'd0);
		send_frame(PAT_EXTREME, 2, geom_width + 1);
	endtask

	task automatic test_back_pressure();
		gap_pct   = 0;
		stall_pct = 0;
		write_geometry(REG_FRAME_WIDTH, 11'd16);
		write_geometry(REG_FRAME_HEIGHT, 11'd4);
		hold_request = 1'b1;
		send_frame(PAT_RANDOM, 0, geom_width + 1);
		send_frame(PAT_SPARSE, 0, geom_width + 1);
	endtask

	task automatic test_random_frames();
		int             start_beats;
		int             frames;
		int             w;
		int             h;
		int             partial;
		pixel_pattern_t pattern;
		start_beats = stream_beats;
		while (stream_beats - start_beats < RANDOM_BEATS) begin
			if ($urandom_range(0, 9) < 2) begin
				gap_pct   = 0;
				stall_pct = 0;
			end else begin
				gap_pct   = $urandom_range(5, 40);
				stall_pct = $urandom_range(5, 40);
			end
			w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(2, 12);
			h = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(2, 6);
			if ($urandom_range(0, 19) == 0) begin
				w = $urandom_range(0, 1);
			end
			if ($urandom_range(0, 19) == 0) begin
				h = $urandom_range(0, 1);
			end
			write_geometry(REG_FRAME_WIDTH, w[CFG_WIDTH-1:0]);
			write_geometry(REG_FRAME_HEIGHT, h[CFG_WIDTH-1:0]);
			frames = $urandom_range(1, 3);
			for (int f = 0; f < frames; f++) begin
				pattern = ($urandom_range(0, 1) == 1) ? PAT_RANDOM :
					pixel_pattern_t'($urandom_range(0, 4));
				case ($urandom_range(0, 19))
					0: begin
						// abandoned frame, the next register write restarts it
						partial = $urandom_range(1, geom_width * geom_height - 1);
						for (int i = 0; i < partial; i++) begin
							send_beat(next_pixel(pattern), 1'b0);
							stream_beats++;
						end
						break;
					end
					1: begin
						// short drain, the next frame's first pixels finish it
						send_frame(pattern, 5, $urandom_range(0, geom_width));
					end
					default: begin
						send_frame(pattern, $urandom_range(0, 10), geom_width + 1);
					end
				endcase
			end
		end
	endtask

	initial begin
		arst_n            <= 1'b0;
		pixel.valid       <= 1'b0;
		pixel.pixel_value <= 8'd0;
		pixel.flush       <= 1'b0;
		cfg_wr_en         <= 1'b0;
		cfg_index         <= REG_FRAME_WIDTH;
		cfg_data          <= '0;
		geom_width  = RESET_WIDTH;
		geom_height = RESET_HEIGHT;
		for (int i = 0; i < MAX_WIDTH_DEF; i++) begin
			row_above[i]  = 8'd0;
			row_middle[i] = 8'd0;
		end
		restart_frame();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_geometry();
		test_saturation();
		test_faint_pixel();
		test_geometry_extremes();
		test_back_pressure();
		test_random_frames();

		pixel.valid <= 1'b0;
		wait_drained();
		if (mismatch_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
